// ===== rtl/sme_pkg.sv =====
// sme_pkg: shared constants, types and helper functions of the stable matching enumerator
// used by sme_ctrl, sme_datapath and stable_matching_enumerator_top
`timescale 1ns / 1ps

package sme_pkg;

  // problem size and derived widths
  localparam int PEOPLE  = 3;
  localparam int IDX_W   = (PEOPLE > 2) ? $clog2(PEOPLE) : 1;
  localparam int CAND_W  = $clog2(PEOPLE + 1);
  localparam int CELLS   = PEOPLE * PEOPLE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int FIELD_W = 2;
  localparam int RANK_W  = 2;
  localparam int CNT_W   = 3;
  localparam int OUT_MEN = 3;
  localparam int MAX_OUT = 6;

  // request codes
  localparam logic [1:0] REQ_MAN_RANK   = 2'd0;
  localparam logic [1:0] REQ_WOMAN_RANK = 2'd1;
  localparam logic [1:0] REQ_START      = 2'd2;

  // power-up rank tables of the 3x3 corner
  localparam logic [RANK_W-1:0] MAN_INIT [0:2][0:2] = '{
    '{2'd0, 2'd2, 2'd1},
    '{2'd0, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd0}
  };
  localparam logic [RANK_W-1:0] WOMAN_INIT [0:2][0:2] = '{
    '{2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd2},
    '{2'd2, 2'd0, 2'd1}
  };

  // controller to datapath commands
  typedef struct packed {
    logic wr_man;
    logic wr_woman;
    logic init;
    logic backtrack;
    logic descend;
    logic next_cand;
    logic chk_start;
    logic chk_next;
    logic rd_sel_b;
    logic sol;
    logic push_last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cand_ovf;
    logic depth_zero;
    logic depth_last;
    logic clash_a;
    logic clash_b;
    logic chk_last;
    logic pend_v;
    logic out_free;
    logic sol_full;
  } dp_stat_t;

  // flat cell address of a rank table entry
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    int a;
    a = int'(row) * PEOPLE + int'(col);
    return ADDR_W'(a);
  endfunction

  // reset value of a rank entry
  function automatic logic [RANK_W-1:0] rank_init(input logic woman,
                                                  input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [RANK_W-1:0] r;
    if (int'(row) < 3 && int'(col) < 3) begin
      r = woman ? WOMAN_INIT[int'(row)][int'(col)] : MAN_INIT[int'(row)][int'(col)];
    end else begin
      r = RANK_W'(col);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sme_ctrl.sv =====
// sme_ctrl: search sequencer of the stable matching enumerator
// depends on sme_pkg; drives sme_datapath through dp_cmd_t
`timescale 1ns / 1ps

module sme_ctrl import sme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_NODE   = 8'b0000_0010,
    S_CHK_A  = 8'b0000_0100,
    S_CHK_B  = 8'b0000_1000,
    S_CHK_C  = 8'b0001_0000,
    S_FIT    = 8'b0010_0000,
    S_SOL    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // input side only takes transfers while no search runs
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_MAN_RANK) begin
            cmd.wr_man = 1'b1;
          end else if (in_req_type == REQ_WOMAN_RANK) begin
            cmd.wr_woman = 1'b1;
          end else if (in_req_type == REQ_START) begin
            cmd.init  = 1'b1;
            state_nxt = S_NODE;
          end
        end
      end
      S_NODE: begin
        if (stat.cand_ovf) begin
          if (stat.depth_zero) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.backtrack = 1'b1;
          end
        end else if (stat.depth_zero) begin
          state_nxt = S_FIT;
        end else begin
          cmd.chk_start = 1'b1;
          state_nxt     = S_CHK_A;
        end
      end
      S_CHK_A: begin
        state_nxt = S_CHK_B;
      end
      S_CHK_B: begin
        cmd.rd_sel_b = 1'b1;
        if (stat.clash_a) begin
          cmd.next_cand = 1'b1;
          state_nxt     = S_NODE;
        end else begin
          state_nxt = S_CHK_C;
        end
      end
      S_CHK_C: begin
        if (stat.clash_b) begin
          cmd.next_cand = 1'b1;
          state_nxt     = S_NODE;
        end else if (stat.chk_last) begin
          state_nxt = S_FIT;
        end else begin
          cmd.chk_next = 1'b1;
          state_nxt    = S_CHK_A;
        end
      end
      S_FIT: begin
        if (stat.depth_last) begin
          state_nxt = S_SOL;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = S_NODE;
        end
      end
      S_SOL: begin
        // wait while the held matching cannot move to the output register
        if (!stat.pend_v || stat.out_free) begin
          cmd.sol = 1'b1;
          if (stat.sol_full) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.next_cand = 1'b1;
            state_nxt     = S_NODE;
          end
        end
      end
      S_FINISH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sme_datapath.sv =====
// sme_datapath: rank memories, search registers, stability check and output register
// depends on sme_pkg; controlled by sme_ctrl through dp_cmd_t
`timescale 1ns / 1ps

module sme_datapath import sme_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [FIELD_W-1:0] in_person,
  input  logic [FIELD_W-1:0] in_partner,
  input  logic [FIELD_W-1:0] in_rank,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   out_solution_number,
  output logic [FIELD_W-1:0] out_wife_of_man_zero,
  output logic [FIELD_W-1:0] out_wife_of_man_one,
  output logic [FIELD_W-1:0] out_wife_of_man_two,
  output logic               out_last_solution
);

  // rank memories with per-entry valid bits
  logic [RANK_W-1:0] man_mem   [CELLS];
  logic [RANK_W-1:0] woman_mem [CELLS];
  logic [CELLS-1:0]  man_vld_r, woman_vld_r;
  logic [RANK_W-1:0] man_q0_r, man_q1_r, woman_q0_r, woman_q1_r;

  // search registers
  logic [IDX_W-1:0]  d_r, i_r;
  logic [CAND_W-1:0] cur_r;
  logic [IDX_W-1:0]  wife_r [PEOPLE];
  logic [CNT_W-1:0]  sol_cnt_r;

  // held matching and output register
  logic               pend_v_r;
  logic [CNT_W-1:0]   pend_num_r;
  logic [FIELD_W-1:0] pend_wife_r [OUT_MEN];
  logic               out_valid_r;
  logic [CNT_W-1:0]   out_num_r;
  logic [FIELD_W-1:0] out_wife_r [OUT_MEN];
  logic               out_last_r;

  logic               wr_ok;
  logic [ADDR_W-1:0]  wr_addr;
  logic [IDX_W-1:0]   d_dec, w_idx, v_idx;
  logic [IDX_W-1:0]   mr0, mc0, mr1, mc1, wr0, wc0, wr1, wc1;
  logic [FIELD_W-1:0] sol_wife [OUT_MEN];
  logic               out_free;

  // write address with range check
  assign wr_ok   = ({1'b0, in_person} < 3'(PEOPLE)) && ({1'b0, in_partner} < 3'(PEOPLE));
  assign wr_addr = cell_addr(in_person[IDX_W-1:0], in_partner[IDX_W-1:0]);

  // man one level up, candidate wife and wife of the earlier man
  assign d_dec = IDX_W'(d_r - IDX_W'(1));
  assign w_idx = cur_r[IDX_W-1:0];
  assign v_idx = wife_r[i_r];

  // read addresses: phase a tests man i with woman w, phase b man d with woman v
  always_comb begin
    if (!cmd.rd_sel_b) begin
      mr0 = i_r;   mc0 = w_idx;
      mr1 = i_r;   mc1 = v_idx;
      wr0 = w_idx; wc0 = i_r;
      wr1 = w_idx; wc1 = d_r;
    end else begin
      mr0 = d_r;   mc0 = v_idx;
      mr1 = d_r;   mc1 = w_idx;
      wr0 = v_idx; wc0 = d_r;
      wr1 = v_idx; wc1 = i_r;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.wr_man && wr_ok) begin
      man_mem[wr_addr] <= in_rank;
    end
    if (cmd.wr_woman && wr_ok) begin
      woman_mem[wr_addr] <= in_rank;
    end
  end

  // valid bits, cleared at reset so entries read as their power-up ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      man_vld_r   <= '0;
      woman_vld_r <= '0;
    end else begin
      if (cmd.wr_man && wr_ok) begin
        man_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.wr_woman && wr_ok) begin
        woman_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // registered reads, two ports per memory
  always_ff @(posedge clk) begin
    man_q0_r   <= man_vld_r[cell_addr(mr0, mc0)] ? man_mem[cell_addr(mr0, mc0)]
                                                 : rank_init(1'b0, mr0, mc0);
    man_q1_r   <= man_vld_r[cell_addr(mr1, mc1)] ? man_mem[cell_addr(mr1, mc1)]
                                                 : rank_init(1'b0, mr1, mc1);
    woman_q0_r <= woman_vld_r[cell_addr(wr0, wc0)] ? woman_mem[cell_addr(wr0, wc0)]
                                                   : rank_init(1'b1, wr0, wc0);
    woman_q1_r <= woman_vld_r[cell_addr(wr1, wc1)] ? woman_mem[cell_addr(wr1, wc1)]
                                                   : rank_init(1'b1, wr1, wc1);
  end

  // search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r       <= '0;
      i_r       <= '0;
      cur_r     <= '0;
      sol_cnt_r <= '0;
    end else begin
      if (cmd.init) begin
        d_r       <= '0;
        cur_r     <= '0;
        sol_cnt_r <= '0;
      end
      if (cmd.backtrack) begin
        d_r   <= d_dec;
        cur_r <= CAND_W'({1'b0, wife_r[d_dec]} + 1'b1);
      end
      if (cmd.descend) begin
        d_r   <= IDX_W'(d_r + IDX_W'(1));
        cur_r <= '0;
      end
      if (cmd.next_cand) begin
        cur_r <= CAND_W'(cur_r + CAND_W'(1));
      end
      if (cmd.chk_start) begin
        i_r <= '0;
      end
      if (cmd.chk_next) begin
        i_r <= IDX_W'(i_r + IDX_W'(1));
      end
      if (cmd.sol) begin
        sol_cnt_r <= CNT_W'(sol_cnt_r + CNT_W'(1));
      end
    end
  end

  // wives of the accepted men
  always_ff @(posedge clk) begin
    if (cmd.descend) begin
      wife_r[d_r] <= w_idx;
    end
  end

  // complete matching in output field order
  for (genvar k = 0; k < OUT_MEN; k++) begin : g_sol
    if (k < PEOPLE - 1) begin : g_held
      assign sol_wife[k] = FIELD_W'(wife_r[k]);
    end else if (k == PEOPLE - 1) begin : g_cur
      assign sol_wife[k] = FIELD_W'(w_idx);
    end else begin : g_none
      assign sol_wife[k] = '0;
    end
  end

  // held matching waits for the next one or the end of the search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.init || cmd.push_last) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.sol) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sol) begin
      pend_num_r  <= CNT_W'(sol_cnt_r + CNT_W'(1));
      pend_wife_r <= sol_wife;
    end
  end

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.sol && pend_v_r) || cmd.push_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.sol && pend_v_r) || cmd.push_last) begin
      out_num_r  <= pend_num_r;
      out_wife_r <= pend_wife_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_solution_number  = out_num_r;
  assign out_wife_of_man_zero = out_wife_r[0];
  assign out_wife_of_man_one  = out_wife_r[1];
  assign out_wife_of_man_two  = out_wife_r[2];
  assign out_last_solution    = out_last_r;

  // status to the controller
  always_comb begin
    stat.cand_ovf   = (cur_r >= CAND_W'(PEOPLE));
    stat.depth_zero = (d_r == '0);
    stat.depth_last = (d_r == IDX_W'(PEOPLE - 1));
    stat.clash_a    = (v_idx == w_idx) ||
                      ((man_q0_r < man_q1_r) && (woman_q0_r < woman_q1_r));
    stat.clash_b    = (man_q0_r < man_q1_r) && (woman_q0_r < woman_q1_r);
    stat.chk_last   = (IDX_W'(i_r + IDX_W'(1)) == d_r);
    stat.pend_v     = pend_v_r;
    stat.out_free   = out_free;
    stat.sol_full   = (sol_cnt_r == CNT_W'(MAX_OUT - 1));
  end

endmodule

// ===== rtl/stable_matching_enumerator_top.sv =====
// stable_matching_enumerator_top: top level of the stable matching enumerator
// depends on sme_pkg, sme_ctrl and sme_datapath
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid / in_stall): req_type 0 writes a man rank entry,
//   1 a woman rank entry (person, partner, rank); 2 starts a search; 3 is dropped.
//   Writes with person or partner out of range are ignored.
// - a write is taken while idle; the block takes a new transfer in the next cycle.
// - a search walks the wife assignments in lexicographic order: it tests each
//   candidate node, checks each earlier man in S_CHK_A, S_CHK_B and, unless
//   phase a clashes, S_CHK_C (two reads of each rank memory per cycle), and
//   then descends or backtracks. in_stall stays high for the whole search.
// - each stable matching leaves on the output channel (out_valid / out_stall)
//   with its running number; a matching is held until the next one is found,
//   so the final one carries out_last_solution. At most six are sent.
// - a stalled result holds in the output register; the search pauses when a new
//   matching is found while a held one waits behind a stalled result, and at
//   the end until the held matching can move to the output register.
// - reset returns the rank tables to their power-up contents through per-entry
//   valid bits at once, and leaves the block idle with no result pending.

module stable_matching_enumerator_top import sme_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [FIELD_W-1:0] in_person,
  input  logic [FIELD_W-1:0] in_partner,
  input  logic [FIELD_W-1:0] in_rank,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   out_solution_number,
  output logic [FIELD_W-1:0] out_wife_of_man_zero,
  output logic [FIELD_W-1:0] out_wife_of_man_one,
  output logic [FIELD_W-1:0] out_wife_of_man_two,
  output logic               out_last_solution
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  sme_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  // memories, search registers and output register
  sme_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_person            (in_person),
    .in_partner           (in_partner),
    .in_rank              (in_rank),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_solution_number  (out_solution_number),
    .out_wife_of_man_zero (out_wife_of_man_zero),
    .out_wife_of_man_one  (out_wife_of_man_one),
    .out_wife_of_man_two  (out_wife_of_man_two),
    .out_last_solution    (out_last_solution)
  );

  // a start transfer makes the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_START)) |=> in_stall)
    else $error("search start did not raise in_stall");

  // a result that is not the last one only shows while the search still runs
  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_solution) |-> in_stall)
    else $error("non-final result shown while idle");

  // running number stays within the emitted range
  a_number_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_solution_number != '0) &&
                   (out_solution_number <= CNT_W'(MAX_OUT))))
    else $error("solution number out of range");

endmodule
